[rtl/core/mfovp_pkg.sv]
// ----------------------------------------------------------------------------
// Meter frame parser package
// Shared types, item layouts, tag codes and the fixed OBIS code table.
// ----------------------------------------------------------------------------
package mfovp_pkg;

   localparam int TABLE_LEN     = 17;
   localparam int QI_POWER_PLUS = 4;
   localparam int QI_CURRENT_L1 = 8;

   localparam logic [7:0] TAG_STRUCT   = 8'h02;
   localparam logic [7:0] TAG_STRING   = 8'h0A;
   localparam logic [7:0] TAG_DATETIME = 8'h0C;
   localparam logic [7:0] TAG_OCTETS   = 8'h09;
   localparam logic [7:0] TAG_U32      = 8'h06;
   localparam logic [7:0] TAG_U16      = 8'h12;
   localparam logic [7:0] HOUR_LAST    = 8'd23;
   localparam logic [7:0] OCTET_CODE_LEN = 8'd6;
   localparam logic [7:0] DATETIME_LEN   = 8'd12;

   localparam logic [2:0] KIND_HEADER_TIME  = 3'd0;
   localparam logic [2:0] KIND_ELEMENT_TIME = 3'd1;
   localparam logic [2:0] KIND_VALUE        = 3'd2;
   localparam logic [2:0] KIND_MAX_CURRENT  = 3'd3;
   localparam logic [2:0] KIND_DAY_POWER    = 3'd4;
   localparam logic [2:0] KIND_FRAME_END    = 3'd5;
   localparam logic [2:0] KIND_FRAME_ERROR  = 3'd6;

   localparam logic [7:0] CODE_TABLE [TABLE_LEN][6] = '{
      '{8'd0, 8'd1, 8'd1,  8'd0, 8'd9, 8'd255},
      '{8'd1, 8'd1, 8'd0,  8'd0, 8'd5, 8'd255},
      '{8'd1, 8'd1, 8'd96, 8'd1, 8'd1, 8'd255},
      '{8'd1, 8'd1, 8'd1,  8'd7, 8'd0, 8'd255},
      '{8'd1, 8'd1, 8'd2,  8'd7, 8'd0, 8'd255},
      '{8'd1, 8'd1, 8'd3,  8'd7, 8'd0, 8'd255},
      '{8'd1, 8'd1, 8'd4,  8'd7, 8'd0, 8'd255},
      '{8'd1, 8'd1, 8'd31, 8'd7, 8'd0, 8'd255},
      '{8'd1, 8'd1, 8'd51, 8'd7, 8'd0, 8'd255},
      '{8'd1, 8'd1, 8'd71, 8'd7, 8'd0, 8'd255},
      '{8'd1, 8'd1, 8'd32, 8'd7, 8'd0, 8'd255},
      '{8'd1, 8'd1, 8'd52, 8'd7, 8'd0, 8'd255},
      '{8'd1, 8'd1, 8'd72, 8'd7, 8'd0, 8'd255},
      '{8'd1, 8'd1, 8'd1,  8'd8, 8'd0, 8'd255},
      '{8'd1, 8'd1, 8'd2,  8'd8, 8'd0, 8'd255},
      '{8'd1, 8'd1, 8'd3,  8'd8, 8'd0, 8'd255},
      '{8'd1, 8'd1, 8'd4,  8'd8, 8'd0, 8'd255}
   };

   typedef enum logic [3:0] {
      PH_IDLE, PH_HEADER, PH_STRUCT, PH_COUNT, PH_TAG, PH_LEN, PH_STRING,
      PH_TIME, PH_NUMBER
   } phase_type;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       frame_start;
   } req_item_type;

   typedef struct packed {
      logic [2:0]  kind;
      logic [4:0]  quantity_index;
      logic [47:0] value;
      logic [15:0] year;
      logic [7:0]  month;
      logic [7:0]  day;
      logic [7:0]  weekday;
      logic [7:0]  hour;
      logic [7:0]  minute;
      logic [7:0]  second;
      logic        last;
   } rsp_item_type;

endpackage

[rtl/core/meter_frame_obis_value_parser_top.sv]
// ----------------------------------------------------------------------------
// Meter frame OBIS value parser
// Byte-wise A-XDR frame parser with OBIS matching and daily statistics.
// ----------------------------------------------------------------------------
// Each item is one frame byte. The parser consumes it in the cycle it is
// accepted and registers at most one result in the output register, so a
// stream of bytes runs at one item per cycle while the output is not stalled.
// A byte that ends a frame also starts a short tail sequencer that emits
// NUM_PHASES maximum currents, the day power total and the frame end marker,
// one per cycle while the output is not stalled; while that tail drains,
// req_stall stays high. Results leave through the output register, which is
// refilled in the cycle it is taken, so the input side keeps moving while the
// consumer takes results.
module meter_frame_obis_value_parser_top
   import mfovp_pkg::*;
#(
   parameter int NUM_QUANTITIES     = 17,
   parameter int CODE_COMPARE_BYTES = 5,
   parameter int NUM_PHASES         = 3,
   parameter int DAY_TOTAL_WIDTH    = 48
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_stall,
   input  req_item_type req_item,
   output logic         rsp_valid,
   input  logic         rsp_stall,
   output rsp_item_type rsp_item
);

   localparam logic [2:0] TAIL_LAST = 3'(NUM_PHASES + 1);

   // Parser state.
   phase_type                     phase_ff, phase_in;
   logic [7:0]                    bytes_left_ff, bytes_left_in;
   logic [7:0]                    hdr_len_ff, hdr_len_in;
   logic [7:0]                    elems_left_ff, elems_left_in;
   logic [7:0]                    tag_ff, tag_in;
   logic [31:0]                   assembly_ff, assembly_in;
   logic [63:0]                   time_ff, time_in;
   logic [NUM_QUANTITIES-1:0]     cand_ff, cand_in;
   logic [4:0]                    match_ff, match_in;
   logic [31:0]                   phase_cur_ff [NUM_PHASES];
   logic [31:0]                   phase_cur_in [NUM_PHASES];
   logic [31:0]                   max_cur_ff [NUM_PHASES];
   logic [31:0]                   max_cur_in [NUM_PHASES];
   logic [31:0]                   power_ff, power_in;
   logic [DAY_TOTAL_WIDTH-1:0]    day_total_ff, day_total_in;
   logic [7:0]                    prev_hour_ff, prev_hour_in;

   // Output side.
   logic                          rsp_valid_ff;
   rsp_item_type                  rsp_item_ff;
   logic                          tail_active_ff, tail_active_in;
   logic [2:0]                    tail_cnt_ff, tail_cnt_in;

   logic                          out_free;
   logic                          accept;
   logic                          prim_valid;
   rsp_item_type                  prim_item;
   logic                          frame_end;
   rsp_item_type                  tail_item;

   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign req_stall = !(out_free && !tail_active_ff);
   assign accept    = req_valid && !req_stall;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_item_ff;

   // Byte parser: next state and the one direct result of the byte.
   always_comb begin
      logic [7:0]                 b;
      logic [7:0]                 pos;
      logic                       hdr_done;
      logic                       elem_done;
      logic                       oct_done;
      logic                       with_time;
      logic [7:0]                 elems_dec;
      logic [DAY_TOTAL_WIDTH:0]   sum;
      logic [63:0]                day_ext;

      b         = req_item.data_byte;
      pos       = 8'd0;
      hdr_done  = 1'b0;
      elem_done = 1'b0;
      oct_done  = 1'b0;
      with_time = 1'b0;
      frame_end = 1'b0;
      elems_dec = 8'd0;
      sum       = '0;
      day_ext   = '0;

      phase_in      = phase_ff;
      bytes_left_in = bytes_left_ff;
      hdr_len_in    = hdr_len_ff;
      elems_left_in = elems_left_ff;
      tag_in        = tag_ff;
      assembly_in   = assembly_ff;
      time_in       = time_ff;
      cand_in       = cand_ff;
      match_in      = match_ff;
      phase_cur_in  = phase_cur_ff;
      max_cur_in    = max_cur_ff;
      power_in      = power_ff;
      day_total_in  = day_total_ff;
      prev_hour_in  = prev_hour_ff;

      prim_valid = 1'b0;
      prim_item  = '0;

      if (accept) begin
         if (req_item.frame_start) begin
            hdr_len_in    = b;
            bytes_left_in = b;
            time_in       = '0;
            if (b == 8'd0) begin
               hdr_done = 1'b1;
            end else begin
               phase_in = PH_HEADER;
            end
         end else begin
            unique case (phase_ff)
               PH_HEADER: begin
                  pos = hdr_len_ff - bytes_left_ff;
                  if (pos < 8'd8) begin
                     time_in[8*(7-pos[2:0]) +: 8] = time_ff[8*(7-pos[2:0]) +: 8] | b;
                  end
                  bytes_left_in = bytes_left_ff - 8'd1;
                  if (bytes_left_in == 8'd0) begin
                     hdr_done = 1'b1;
                  end
               end
               PH_STRUCT: begin
                  if (b != TAG_STRUCT) begin
                     prim_valid     = 1'b1;
                     prim_item.kind = KIND_FRAME_ERROR;
                     phase_in       = PH_IDLE;
                  end else begin
                     phase_in = PH_COUNT;
                  end
               end
               PH_COUNT: begin
                  elems_left_in = b;
                  if (b == 8'd0) begin
                     frame_end = 1'b1;
                  end else begin
                     phase_in = PH_TAG;
                  end
               end
               PH_TAG: begin
                  tag_in = b;
                  if (b == TAG_DATETIME) begin
                     bytes_left_in = DATETIME_LEN;
                     time_in       = '0;
                     phase_in      = PH_TIME;
                  end else if (b == TAG_U32 || b == TAG_U16) begin
                     bytes_left_in = (b == TAG_U32) ? 8'd4 : 8'd2;
                     assembly_in   = '0;
                     phase_in      = PH_NUMBER;
                  end else begin
                     if (b == TAG_STRING || b == TAG_OCTETS) begin
                        match_in = '0;
                     end
                     cand_in  = '1;
                     phase_in = PH_LEN;
                  end
               end
               PH_LEN: begin
                  hdr_len_in    = b;
                  bytes_left_in = b;
                  if (b == 8'd0) begin
                     oct_done  = (tag_ff == TAG_OCTETS);
                     elem_done = 1'b1;
                  end else begin
                     phase_in = PH_STRING;
                  end
               end
               PH_STRING: begin
                  pos = hdr_len_ff - bytes_left_ff;
                  if (tag_ff == TAG_OCTETS && pos < 8'(CODE_COMPARE_BYTES)) begin
                     for (int i = 0; i < NUM_QUANTITIES; i++) begin
                        if (i < TABLE_LEN) begin
                           if (CODE_TABLE[i][pos[2:0]] != b) begin
                              cand_in[i] = 1'b0;
                           end
                        end
                     end
                  end
                  bytes_left_in = bytes_left_ff - 8'd1;
                  if (bytes_left_in == 8'd0) begin
                     oct_done  = (tag_ff == TAG_OCTETS);
                     elem_done = 1'b1;
                  end
               end
               PH_TIME: begin
                  pos = DATETIME_LEN - bytes_left_ff;
                  if (pos < 8'd8) begin
                     time_in[8*(7-pos[2:0]) +: 8] = time_ff[8*(7-pos[2:0]) +: 8] | b;
                  end
                  bytes_left_in = bytes_left_ff - 8'd1;
                  if (bytes_left_in == 8'd0) begin
                     prim_valid     = 1'b1;
                     prim_item.kind = KIND_ELEMENT_TIME;
                     with_time      = 1'b1;
                     elem_done      = 1'b1;
                  end
               end
               PH_NUMBER: begin
                  assembly_in   = {assembly_ff[23:0], b};
                  bytes_left_in = bytes_left_ff - 8'd1;
                  if (bytes_left_in == 8'd0) begin
                     prim_valid               = 1'b1;
                     prim_item.kind           = KIND_VALUE;
                     prim_item.quantity_index = match_ff;
                     prim_item.value          = {16'd0, assembly_in};
                     for (int p = 0; p < NUM_PHASES; p++) begin
                        if (match_ff == 5'(QI_CURRENT_L1 + p)) begin
                           phase_cur_in[p] = assembly_in;
                        end
                     end
                     if (match_ff == 5'(QI_POWER_PLUS)) begin
                        power_in = assembly_in;
                     end
                     match_in  = '0;
                     elem_done = 1'b1;
                  end
               end
               default: begin
               end
            endcase
         end

         // An octet string of code length picks the highest surviving entry.
         if (oct_done) begin
            match_in = '0;
            if (hdr_len_in == OCTET_CODE_LEN) begin
               for (int i = 0; i < NUM_QUANTITIES; i++) begin
                  if (i < TABLE_LEN && cand_in[i]) begin
                     match_in = 5'(i + 1);
                  end
               end
            end
         end

         if (elem_done) begin
            elems_dec     = elems_left_ff - 8'd1;
            elems_left_in = elems_dec;
            if (elems_dec == 8'd0) begin
               frame_end = 1'b1;
            end else begin
               phase_in = PH_TAG;
            end
         end

         if (hdr_done) begin
            prim_valid     = 1'b1;
            prim_item.kind = KIND_HEADER_TIME;
            with_time      = 1'b1;
            // Midnight rollover clears the daily statistics.
            if (time_in[23:16] == 8'd0 && prev_hour_ff == HOUR_LAST) begin
               for (int p = 0; p < NUM_PHASES; p++) begin
                  max_cur_in[p] = '0;
               end
               day_total_in = '0;
            end
            prev_hour_in = time_in[23:16];
            phase_in     = PH_STRUCT;
         end

         if (frame_end) begin
            for (int p = 0; p < NUM_PHASES; p++) begin
               if (phase_cur_in[p] > max_cur_ff[p]) begin
                  max_cur_in[p] = phase_cur_in[p];
               end
            end
            sum = {1'b0, day_total_ff} + (DAY_TOTAL_WIDTH + 1)'(power_in);
            if (sum[DAY_TOTAL_WIDTH]) begin
               day_total_in = '1;
            end else begin
               day_total_in = sum[DAY_TOTAL_WIDTH-1:0];
            end
            phase_in = PH_IDLE;
         end
      end

      if (with_time) begin
         prim_item.year    = time_in[63:48];
         prim_item.month   = time_in[47:40];
         prim_item.day     = time_in[39:32];
         prim_item.weekday = time_in[31:24];
         prim_item.hour    = time_in[23:16];
         prim_item.minute  = time_in[15:8];
         prim_item.second  = time_in[7:0];
      end
      prim_item.last = !frame_end;

      // Frame-end tail item selected by the tail counter.
      tail_item = '0;
      day_ext   = 64'(day_total_ff);
      for (int p = 0; p < NUM_PHASES; p++) begin
         if (tail_cnt_ff == 3'(p)) begin
            tail_item.kind           = KIND_MAX_CURRENT;
            tail_item.quantity_index = 5'(p);
            tail_item.value          = {16'd0, max_cur_ff[p]};
         end
      end
      if (tail_cnt_ff == 3'(NUM_PHASES)) begin
         tail_item.kind  = KIND_DAY_POWER;
         tail_item.value = day_ext[47:0];
      end
      if (tail_cnt_ff == TAIL_LAST) begin
         tail_item.kind = KIND_FRAME_END;
         tail_item.last = 1'b1;
      end
   end

   always_comb begin
      tail_active_in = tail_active_ff;
      tail_cnt_in    = tail_cnt_ff;
      if (accept && frame_end) begin
         tail_active_in = 1'b1;
         tail_cnt_in    = '0;
      end else if (tail_active_ff && out_free) begin
         tail_cnt_in = tail_cnt_ff + 3'd1;
         if (tail_cnt_ff == TAIL_LAST) begin
            tail_active_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff       <= PH_IDLE;
         bytes_left_ff  <= '0;
         hdr_len_ff     <= '0;
         elems_left_ff  <= '0;
         tag_ff         <= '0;
         assembly_ff    <= '0;
         time_ff        <= '0;
         cand_ff        <= '1;
         match_ff       <= '0;
         for (int p = 0; p < NUM_PHASES; p++) begin
            phase_cur_ff[p] <= '0;
            max_cur_ff[p]   <= '0;
         end
         power_ff       <= '0;
         day_total_ff   <= '0;
         prev_hour_ff   <= '0;
         rsp_valid_ff   <= 1'b0;
         tail_active_ff <= 1'b0;
         tail_cnt_ff    <= '0;
      end else begin
         phase_ff       <= phase_in;
         bytes_left_ff  <= bytes_left_in;
         hdr_len_ff     <= hdr_len_in;
         elems_left_ff  <= elems_left_in;
         tag_ff         <= tag_in;
         assembly_ff    <= assembly_in;
         time_ff        <= time_in;
         cand_ff        <= cand_in;
         match_ff       <= match_in;
         phase_cur_ff   <= phase_cur_in;
         max_cur_ff     <= max_cur_in;
         power_ff       <= power_in;
         day_total_ff   <= day_total_in;
         prev_hour_ff   <= prev_hour_in;
         tail_active_ff <= tail_active_in;
         tail_cnt_ff    <= tail_cnt_in;
         if (accept && prim_valid) begin
            rsp_valid_ff <= 1'b1;
         end else if (tail_active_ff && out_free) begin
            rsp_valid_ff <= 1'b1;
         end else if (out_free) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept && prim_valid) begin
         rsp_item_ff <= prim_item;
      end else if (tail_active_ff && out_free) begin
         rsp_item_ff <= tail_item;
      end
   end

   // No byte is taken while the frame-end tail is still draining.
   a_tail_blocks_input: assert property (@(posedge clock) disable iff (reset)
      tail_active_ff |-> req_stall)
      else $error("input accepted during frame-end tail");

   // The frame end marker always closes the results of its byte.
   a_end_is_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_item_ff.kind == KIND_FRAME_END |-> rsp_item_ff.last)
      else $error("frame end result without last flag");

   // A frame-ending byte is followed by the tail sequencer.
   a_tail_starts: assert property (@(posedge clock) disable iff (reset)
      accept && frame_end |=> tail_active_ff && tail_cnt_ff == 3'd0)
      else $error("frame-end tail did not start");

   a_no_rsp_after_reset: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid_ff)
      else $error("result valid right after reset");

endmodule

[bench/meter_frame_obis_value_parser_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Meter frame parser checker
// Watches both channels, predicts every result from the accepted bytes and
// compares each accepted result field by field with the oldest prediction.
// ----------------------------------------------------------------------------
module meter_frame_obis_value_parser_checker
   import mfovp_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   input  logic         req_stall,
   input  req_item_type req_item,
   input  logic         rsp_valid,
   input  logic         rsp_stall,
   input  rsp_item_type rsp_item,
   output int           fail_count,
   output int           pending_count
);

   localparam int NQ = 17;
   localparam int NP = 3;
   localparam logic [47:0] DAY_MAX = '1;

   rsp_item_type expected_rsps[$];

   phase_type   phase;
   logic [7:0]  left_cnt, hdr_len, elem_left, tag;
   logic [31:0] assembly;
   logic [63:0] stamp;
   logic [16:0] cands;
   logic [4:0]  match;
   logic [31:0] cur [NP];
   logic [31:0] cur_max [NP];
   logic [31:0] power;
   logic [47:0] day_total;
   logic [7:0]  prev_hour;

   assign pending_count = expected_rsps.size();

   task automatic push_rsp(logic [2:0] k, logic [4:0] q, logic [47:0] v, bit with_time);
      rsp_item_type r;
      logic [63:0] t;
      t = with_time ? stamp : 64'd0;
      r.kind = k; r.quantity_index = q; r.value = v;
      r.year = t[63:48]; r.month = t[47:40]; r.day = t[39:32];
      r.weekday = t[31:24]; r.hour = t[23:16]; r.minute = t[15:8];
      r.second = t[7:0]; r.last = 1'b0;
      expected_rsps.push_back(r);
   endtask

   task automatic put_stamp(int pos, logic [7:0] b);
      if (pos < 8) stamp[8*(7-pos) +: 8] |= b;
   endtask

   task automatic finish_header();
      logic [7:0] h;
      h = stamp[23:16];
      push_rsp(KIND_HEADER_TIME, 0, 0, 1);
      if (h == 8'd0 && prev_hour == HOUR_LAST) begin
         for (int p = 0; p < NP; p++) cur_max[p] = 0;
         day_total = 0;
      end
      prev_hour = h;
      phase = PH_STRUCT;
   endtask

   task automatic finish_frame();
      for (int p = 0; p < NP; p++) begin
         if (cur[p] > cur_max[p]) cur_max[p] = cur[p];
         push_rsp(KIND_MAX_CURRENT, p[4:0], {16'd0, cur_max[p]}, 0);
      end
      if (day_total > DAY_MAX - {16'd0, power}) day_total = DAY_MAX;
      else day_total = day_total + {16'd0, power};
      push_rsp(KIND_DAY_POWER, 0, day_total, 0);
      push_rsp(KIND_FRAME_END, 0, 0, 0);
      phase = PH_IDLE;
   endtask

   task automatic finish_element();
      elem_left = elem_left - 8'd1;
      if (elem_left == 0) finish_frame();
      else phase = PH_TAG;
   endtask

   task automatic resolve_code();
      match = 0;
      if (hdr_len == OCTET_CODE_LEN)
         for (int i = 0; i < NQ; i++)
            if (cands[i]) match = 5'(i + 1);
   endtask

   // Advances the parser prediction by one accepted byte.
   task automatic predict_byte(req_item_type it);
      int n0;
      logic [7:0] b;
      logic [7:0] pos;
      b = it.data_byte;
      n0 = expected_rsps.size();
      if (it.frame_start) begin
         hdr_len = b; left_cnt = b; stamp = 0;
         if (b == 0) finish_header();
         else phase = PH_HEADER;
      end else begin
         case (phase)
            PH_HEADER: begin
               put_stamp(int'(8'(hdr_len - left_cnt)), b);
               left_cnt--;
               if (left_cnt == 0) finish_header();
            end
            PH_STRUCT: begin
               if (b != TAG_STRUCT) begin
                  push_rsp(KIND_FRAME_ERROR, 0, 0, 0);
                  phase = PH_IDLE;
               end else phase = PH_COUNT;
            end
            PH_COUNT: begin
               elem_left = b;
               if (b == 0) finish_frame();
               else phase = PH_TAG;
            end
            PH_TAG: begin
               tag = b;
               if (b == TAG_DATETIME) begin
                  left_cnt = DATETIME_LEN; stamp = 0; phase = PH_TIME;
               end else if (b == TAG_U32 || b == TAG_U16) begin
                  left_cnt = (b == TAG_U32) ? 8'd4 : 8'd2;
                  assembly = 0; phase = PH_NUMBER;
               end else begin
                  if (b == TAG_STRING || b == TAG_OCTETS) match = 0;
                  cands = '1;
                  phase = PH_LEN;
               end
            end
            PH_LEN: begin
               hdr_len = b; left_cnt = b;
               if (b == 0) begin
                  if (tag == TAG_OCTETS) resolve_code();
                  finish_element();
               end else phase = PH_STRING;
            end
            PH_STRING: begin
               pos = hdr_len - left_cnt;
               if (tag == TAG_OCTETS && pos < 5)
                  for (int i = 0; i < NQ; i++)
                     if (CODE_TABLE[i][pos] != b) cands[i] = 1'b0;
               left_cnt--;
               if (left_cnt == 0) begin
                  if (tag == TAG_OCTETS) resolve_code();
                  finish_element();
               end
            end
            PH_TIME: begin
               put_stamp(int'(8'(DATETIME_LEN - left_cnt)), b);
               left_cnt--;
               if (left_cnt == 0) begin
                  push_rsp(KIND_ELEMENT_TIME, 0, 0, 1);
                  finish_element();
               end
            end
            PH_NUMBER: begin
               assembly = {assembly[23:0], b};
               left_cnt--;
               if (left_cnt == 0) begin
                  push_rsp(KIND_VALUE, match, {16'd0, assembly}, 0);
                  if (match >= QI_CURRENT_L1 && match < QI_CURRENT_L1 + NP)
                     cur[match - QI_CURRENT_L1] = assembly;
                  if (match == QI_POWER_PLUS) power = assembly;
                  match = 0;
                  finish_element();
               end
            end
            default: ;
         endcase
      end
      if (expected_rsps.size() > n0)
         expected_rsps[expected_rsps.size()-1].last = 1'b1;
   endtask

   task automatic compare_rsp(rsp_item_type got);
      rsp_item_type e;
      if (expected_rsps.size() == 0) begin
         $error("unexpected result kind=%0d", got.kind);
         fail_count++;
         return;
      end
      e = expected_rsps.pop_front();
      if (got.kind !== e.kind) begin
         $error("kind expected %0d actual %0d", e.kind, got.kind); fail_count++; end
      if (got.quantity_index !== e.quantity_index) begin
         $error("quantity_index expected %0d actual %0d", e.quantity_index,
                got.quantity_index); fail_count++; end
      if (got.value !== e.value) begin
         $error("value expected %0h actual %0h", e.value, got.value); fail_count++; end
      if (got.year !== e.year) begin
         $error("year expected %0h actual %0h", e.year, got.year); fail_count++; end
      if (got.month !== e.month) begin
         $error("month expected %0h actual %0h", e.month, got.month); fail_count++; end
      if (got.day !== e.day) begin
         $error("day expected %0h actual %0h", e.day, got.day); fail_count++; end
      if (got.weekday !== e.weekday) begin
         $error("weekday expected %0h actual %0h", e.weekday, got.weekday); fail_count++; end
      if (got.hour !== e.hour) begin
         $error("hour expected %0h actual %0h", e.hour, got.hour); fail_count++; end
      if (got.minute !== e.minute) begin
         $error("minute expected %0h actual %0h", e.minute, got.minute); fail_count++; end
      if (got.second !== e.second) begin
         $error("second expected %0h actual %0h", e.second, got.second); fail_count++; end
      if (got.last !== e.last) begin
         $error("last expected %0b actual %0b", e.last, got.last); fail_count++; end
   endtask

   initial fail_count = 0;

   always @(posedge clock) begin
      if (reset) begin
         phase = PH_IDLE;
         left_cnt = 0; hdr_len = 0; elem_left = 0; tag = 0;
         assembly = 0; stamp = 0; cands = '1; match = 0;
         for (int p = 0; p < NP; p++) begin cur[p] = 0; cur_max[p] = 0; end
         power = 0; day_total = 0; prev_hour = 0;
         expected_rsps.delete();
      end else begin
         // Results are compared before the byte of this edge is predicted;
         // a result can never leave in the cycle its byte is accepted.
         if (rsp_valid && !rsp_stall) compare_rsp(rsp_item);
         if (req_valid && !req_stall) predict_byte(req_item);
      end
   end

endmodule

[bench/meter_frame_obis_value_parser_top_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Meter frame parser testbench
// Feeds directed and random meter frames in bursts against a stalling
// receiver; the checker predicts and compares every result.
// ----------------------------------------------------------------------------
module meter_frame_obis_value_parser_top_tb;
   import mfovp_pkg::*;

   logic         clock = 1'b0;
   logic         reset = 1'b1;
   logic         req_valid = 1'b0;
   logic         req_stall;
   req_item_type req_item = '0;
   logic         rsp_valid;
   logic         rsp_stall = 1'b0;
   rsp_item_type rsp_item;
   int           fail_count;
   int           pending_count;
   int           sent_count = 0;
   bit           stall_random = 1'b0;

   always #4 clock = ~clock;

   meter_frame_obis_value_parser_top uut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_item(req_item),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_item(rsp_item)
   );

   meter_frame_obis_value_parser_checker checker_i (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_item(req_item),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_item(rsp_item),
      .fail_count(fail_count), .pending_count(pending_count)
   );

   // The receiver alternates between free-running stretches and stretches
   // where it stalls about a third of the time.
   int stall_phase = 0;
   always @(negedge clock) begin
      stall_phase <= (stall_phase + 1) % 97;
      if (!stall_random || stall_phase < 30) rsp_stall <= 1'b0;
      else rsp_stall <= ($urandom_range(0, 2) == 0);
   end

   // Bytes for one frame are queued first, then sent in bursts.
   logic [8:0] byte_queue[$];
   int         burst_left = 0;

   task automatic put_byte(logic [7:0] b, bit start = 1'b0);
      byte_queue.push_back({b, start});
   endtask

   // The sender drops valid only for a gap between bursts, and the trailing
   // idle wait keeps the next call out of the same time step.
   task automatic send_all();
      logic [8:0] w;
      int         gap;
      while (byte_queue.size() > 0) begin
         w = byte_queue.pop_front();
         if (burst_left == 0) begin
            gap = $urandom_range(0, 4);
            if (gap > 0) begin
               req_valid <= 1'b0;
               repeat (gap) @(negedge clock);
            end
            burst_left = $urandom_range(1, 20);
         end
         req_item <= {w[8:1], w[0]};
         req_valid <= 1'b1;
         @(posedge clock);
         while (req_stall) @(posedge clock);
         @(negedge clock);
         burst_left--;
         sent_count++;
      end
      req_valid <= 1'b0;
      @(negedge clock);
   endtask

   task automatic put_header(int len, logic [7:0] hour);
      put_byte(8'(len), 1'b1);
      for (int i = 0; i < len; i++)
         put_byte(i == 5 ? hour : 8'($urandom));
   endtask

   // One tagged element; a code element may name a table entry.
   task automatic put_element();
      int sel, k;
      sel = $urandom_range(0, 9);
      case (sel)
         0, 1, 2: begin
            k = $urandom_range(0, TABLE_LEN - 1);
            put_byte(TAG_OCTETS); put_byte(OCTET_CODE_LEN);
            for (int j = 0; j < 6; j++)
               put_byte(($urandom_range(0, 15) == 0) ? 8'($urandom) : CODE_TABLE[k][j]);
         end
         3, 4: begin
            put_byte(TAG_U32);
            for (int j = 0; j < 4; j++)
               put_byte(($urandom_range(0, 3) == 0) ? 8'hFF : 8'($urandom));
         end
         5: begin
            put_byte(TAG_U16); put_byte(8'($urandom)); put_byte(8'($urandom));
         end
         6: begin
            put_byte(TAG_DATETIME);
            for (int j = 0; j < 12; j++) put_byte(8'($urandom));
         end
         7: begin
            k = $urandom_range(0, 4);
            put_byte(($urandom_range(0, 1) == 0) ? TAG_STRING : TAG_OCTETS);
            put_byte(8'(k));
            for (int j = 0; j < k; j++) put_byte(8'($urandom));
         end
         default: begin
            k = $urandom_range(0, 3);
            put_byte(8'($urandom_range(0, 1) ? 8'h00 : 8'hFF)); put_byte(8'(k));
            for (int j = 0; j < k; j++) put_byte(8'($urandom));
         end
      endcase
   endtask

   task automatic put_frame(int n_elem, logic [7:0] hour);
      put_header($urandom_range(0, 9) == 0 ? $urandom_range(0, 7) : 12, hour);
      put_byte(TAG_STRUCT);
      put_byte(8'(n_elem));
      for (int e = 0; e < n_elem; e++) put_element();
   endtask

   initial begin
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Directed: empty header, empty frame, missing struct tag.
      put_byte(8'd0, 1'b1); put_byte(TAG_STRUCT); put_byte(8'd0);
      put_byte(8'd3, 1'b1); put_byte(8'hFF); put_byte(8'h00); put_byte(8'h07);
      put_byte(8'h55);
      // Current on phase one at maximum.
      put_header(12, 8'd23); put_byte(TAG_STRUCT); put_byte(8'd2);
      put_byte(TAG_OCTETS); put_byte(8'd6);
      for (int j = 0; j < 6; j++) put_byte(CODE_TABLE[QI_CURRENT_L1 - 1][j]);
      put_byte(TAG_U32); repeat (4) put_byte(8'hFF);
      send_all();
      // Stray idle byte, a dropped frame, then a midnight frame.
      put_byte(8'hAA); put_byte(8'd4, 1'b1); put_byte(8'h01);
      put_header(8, 8'd0); put_byte(TAG_STRUCT); put_byte(8'd1);
      put_byte(TAG_U16); put_byte(8'hFF); put_byte(8'hFF);
      send_all();

      stall_random = 1'b1;
      while (sent_count < 370) begin
         if ($urandom_range(0, 19) == 0) begin
            // Noise or a broken frame.
            repeat ($urandom_range(1, 5)) put_byte(8'($urandom), $urandom_range(0, 3) == 0);
         end else begin
            put_frame($urandom_range(0, 6),
                      $urandom_range(0, 2) == 0 ? 8'($urandom_range(22, 23)) :
                      ($urandom_range(0, 1) ? 8'd0 : 8'($urandom)));
         end
         send_all();
         if ($urandom_range(0, 7) == 0) begin
            // Hold off until every expected result has arrived.
            while (pending_count != 0) @(negedge clock);
         end
      end

      while (pending_count != 0) @(negedge clock);
      repeat (50) @(negedge clock);
      if (fail_count == 0 && pending_count == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

   initial begin
      #2000000;
      $display("TB_ERROR");
      $finish;
   end

endmodule
